// ===== design/playfair_digraph_cipher_top_defines.svh =====
// ----------------------------------------------------------------------------
// Playfair cipher assertion macros
// Assertion wrappers used by the Playfair cipher back end. They expand to
// nothing when the design is synthesized.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_CIPHER_TOP_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PDC_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define PDC_ASSERT_RST(name, prop) \
   name: assert property (@(posedge clock) prop) else $error("assertion failed");
`else
`define PDC_ASSERT(name, prop)
`define PDC_ASSERT_RST(name, prop)
`endif
`endif

// ===== design/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Playfair cipher package
// Shared constants, beat types and queue status for the Playfair cipher.
// ----------------------------------------------------------------------------
package pdc_pkg;

   localparam int SQ_SIZE   = 25;
   localparam int SQ_SIDE   = 5;
   localparam int POS_W     = $clog2(SQ_SIZE);
   localparam int FILL_W    = $clog2(SQ_SIZE + 1);
   localparam int RC_W      = $clog2(SQ_SIDE);
   localparam int CHAR_BITS = 8;
   localparam int CMD_W     = 3;

   localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_KEY      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_COMPLETE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TEXT     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FLUSH    = 3'd4;

   localparam logic [CHAR_BITS-1:0] CHAR_BLANK = 8'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_A     = 8'd97;
   localparam logic [CHAR_BITS-1:0] CHAR_W     = 8'd119;
   localparam logic [CHAR_BITS-1:0] CHAR_X     = 8'd120;
   localparam logic [CHAR_BITS-1:0] CHAR_Z     = 8'd122;

   localparam int OPQ_DEPTH  = 2;
   localparam int OPQ_PTR_W  = $clog2(OPQ_DEPTH);
   localparam int OPQ_CNT_W  = $clog2(OPQ_DEPTH + 1);
   localparam int RSPQ_DEPTH = 2;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [CHAR_BITS-1:0] character;
   } req_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] out_char;
      logic                 last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_KEY,
      OP_COMPLETE,
      OP_PAIR
   } op_kind_type;

   typedef struct packed {
      op_kind_type          kind;
      logic [CHAR_BITS-1:0] char_a;
      logic [CHAR_BITS-1:0] char_b;
      logic                 decrypt;
   } op_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

// ===== design/pdc_front.sv =====
// ----------------------------------------------------------------------------
// Playfair cipher front end
// Accepts command beats, tracks the pending letter and the mode register,
// and turns the beats into square operations and digraph jobs.
// ----------------------------------------------------------------------------
module pdc_front import pdc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_push,
   input  req_type   req_data,
   output logic      req_full,
   input  logic      csr_valid,
   output logic      csr_ready,
   input  logic      csr_data,
   output logic      op_push,
   output op_type    op_data,
   input  qstat_type opq_stat
);

   logic                 decrypt_mode_ff, decrypt_mode_in;
   logic [CHAR_BITS-1:0] pending_char_ff, pending_char_in;
   logic                 pending_valid_ff, pending_valid_in;
   logic                 accept;
   logic [CHAR_BITS-1:0] c;

   function automatic logic [CHAR_BITS-1:0] pad_for(input logic [CHAR_BITS-1:0] ch);
      return (ch == CHAR_X) ? CHAR_Z : CHAR_X;
   endfunction

   assign req_full  = opq_stat.full;
   assign csr_ready = 1'b1;
   assign accept    = req_push & ~opq_stat.full;
   assign c         = req_data.character;

   always_comb begin
      decrypt_mode_in  = csr_valid ? csr_data : decrypt_mode_ff;
      pending_char_in  = pending_char_ff;
      pending_valid_in = pending_valid_ff;
      op_push          = 1'b0;
      op_data.kind     = OP_CLEAR;
      op_data.char_a   = c;
      op_data.char_b   = c;
      op_data.decrypt  = decrypt_mode_ff;
      if (accept) begin
         case (req_data.command)
            CMD_CLEAR: begin
               op_push      = 1'b1;
               op_data.kind = OP_CLEAR;
            end
            CMD_KEY: begin
               op_push      = 1'b1;
               op_data.kind = OP_KEY;
            end
            CMD_COMPLETE: begin
               op_push      = 1'b1;
               op_data.kind = OP_COMPLETE;
            end
            CMD_TEXT: begin
               if (decrypt_mode_ff) begin
                  if (!pending_valid_ff) begin
                     pending_char_in  = c;
                     pending_valid_in = 1'b1;
                  end else begin
                     pending_valid_in = 1'b0;
                     op_push          = 1'b1;
                     op_data.kind     = OP_PAIR;
                     op_data.char_a   = pending_char_ff;
                  end
               end else if (c inside {[CHAR_A:CHAR_Z]}) begin
                  if (!pending_valid_ff) begin
                     pending_char_in  = c;
                     pending_valid_in = 1'b1;
                  end else if (pending_char_ff == c) begin
                     op_push        = 1'b1;
                     op_data.kind   = OP_PAIR;
                     op_data.char_b = pad_for(c);
                  end else begin
                     pending_valid_in = 1'b0;
                     op_push          = 1'b1;
                     op_data.kind     = OP_PAIR;
                     op_data.char_a   = pending_char_ff;
                  end
               end
            end
            CMD_FLUSH: begin
               if (pending_valid_ff) begin
                  pending_valid_in = 1'b0;
                  if (!decrypt_mode_ff) begin
                     op_push        = 1'b1;
                     op_data.kind   = OP_PAIR;
                     op_data.char_a = pending_char_ff;
                     op_data.char_b = pad_for(pending_char_ff);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_mode_ff  <= 1'b0;
         pending_char_ff  <= '0;
         pending_valid_ff <= 1'b0;
      end else begin
         decrypt_mode_ff  <= decrypt_mode_in;
         pending_char_ff  <= pending_char_in;
         pending_valid_ff <= pending_valid_in;
      end
   end

endmodule

// ===== design/pdc_op_queue.sv =====
// ----------------------------------------------------------------------------
// Playfair cipher operation queue
// Short queue that carries operations from the front end to the back end.
// ----------------------------------------------------------------------------
module pdc_op_queue import pdc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  op_type    push_data,
   input  logic      pop,
   output op_type    head,
   output qstat_type stat
);

   op_type                 entry_ff [OPQ_DEPTH];
   logic [OPQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OPQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OPQ_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == OPQ_CNT_W'(OPQ_DEPTH));
   assign do_push    = push & ~stat.full;
   assign do_pop     = pop & ~stat.empty;
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/pdc_back.sv =====
// ----------------------------------------------------------------------------
// Playfair cipher back end
// Holds the key square, runs the square operations and the completion walk,
// and enciphers or deciphers each digraph into two result beats.
// ----------------------------------------------------------------------------
`include "playfair_digraph_cipher_top_defines.svh"

module pdc_back import pdc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  op_type    op_head,
   input  qstat_type opq_stat,
   output logic      op_pop,
   output logic      rsp_push,
   output rsp_type   rsp_push_data,
   input  qstat_type rsp_stat
);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_COMPLETE = 5'b00010,
      S_CALC     = 5'b00100,
      S_EMIT0    = 5'b01000,
      S_EMIT1    = 5'b10000
   } state_type;

   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] pos;
   } find_type;

   state_type            state_ff, state_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [CHAR_BITS-1:0] letter_ff, letter_in;
   logic [CHAR_BITS-1:0] sq_ff [SQ_SIZE];
   logic [CHAR_BITS-1:0] sq_mem [SQ_SIZE];
   logic [POS_W-1:0]     pos_a_ff, pos_b_ff;
   logic                 dec_ff;
   logic [CHAR_BITS-1:0] rd_a_ff, rd_b_ff;
   logic                 in_a_ff, in_b_ff;
   logic [CHAR_BITS-1:0] srch_a_char;
   find_type             find_a, find_b;
   logic                 wr_en;
   logic                 pair_load;
   logic [RC_W-1:0]      ra, ca, rb, cb, sh;
   logic [POS_W-1:0]     oa, ob;

   function automatic find_type find_char(input logic [CHAR_BITS-1:0] ch,
                                          input logic [CHAR_BITS-1:0] sq [SQ_SIZE],
                                          input logic [FILL_W-1:0] fill);
      find_type r;
      logic     m;
      r = '0;
      for (int k = SQ_SIZE - 1; k >= 0; k--) begin
         m = (FILL_W'(k) < fill) ? (sq[k] == ch) : (ch == CHAR_BLANK);
         if (m) begin
            r.hit = 1'b1;
            r.pos = POS_W'(k);
         end
      end
      return r;
   endfunction

   function automatic logic [RC_W-1:0] pos_row(input logic [POS_W-1:0] p);
      logic [RC_W-1:0] r;
      r = '0;
      for (int i = 1; i < SQ_SIDE; i++) begin
         if (p >= POS_W'(i * SQ_SIDE)) begin
            r = RC_W'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [RC_W-1:0] pos_col(input logic [POS_W-1:0] p);
      return RC_W'(p - POS_W'(int'(pos_row(p)) * SQ_SIDE));
   endfunction

   function automatic logic [RC_W-1:0] add_mod(input logic [RC_W-1:0] x,
                                               input logic [RC_W-1:0] s);
      logic [RC_W:0] t;
      t = {1'b0, x} + {1'b0, s};
      if (t >= (RC_W + 1)'(SQ_SIDE)) begin
         t = t - (RC_W + 1)'(SQ_SIDE);
      end
      return t[RC_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] rc_pos(input logic [RC_W-1:0] r,
                                               input logic [RC_W-1:0] cc);
      return POS_W'(int'(r) * SQ_SIDE + int'(cc));
   endfunction

   assign srch_a_char = (state_ff == S_COMPLETE) ? letter_ff : op_head.char_a;
   assign find_a      = find_char(srch_a_char, sq_ff, fill_ff);
   assign find_b      = find_char(op_head.char_b, sq_ff, fill_ff);

   always_comb begin
      ra = pos_row(pos_a_ff);
      ca = pos_col(pos_a_ff);
      rb = pos_row(pos_b_ff);
      cb = pos_col(pos_b_ff);
      sh = dec_ff ? RC_W'(SQ_SIDE - 1) : RC_W'(1);
      if (ra == rb) begin
         oa = rc_pos(ra, add_mod(ca, sh));
         ob = rc_pos(rb, add_mod(cb, sh));
      end else if (ca == cb) begin
         oa = rc_pos(add_mod(ra, sh), ca);
         ob = rc_pos(add_mod(rb, sh), cb);
      end else begin
         oa = rc_pos(ra, cb);
         ob = rc_pos(rb, ca);
      end
   end

   always_comb begin
      state_in               = state_ff;
      fill_in                = fill_ff;
      letter_in              = letter_ff;
      op_pop                 = 1'b0;
      wr_en                  = 1'b0;
      pair_load              = 1'b0;
      rsp_push               = 1'b0;
      rsp_push_data.out_char = in_a_ff ? rd_a_ff : CHAR_BLANK;
      rsp_push_data.last     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!opq_stat.empty) begin
               case (op_head.kind)
                  OP_CLEAR: begin
                     op_pop  = 1'b1;
                     fill_in = '0;
                  end
                  OP_KEY: begin
                     op_pop = 1'b1;
                     if (op_head.char_a != CHAR_BLANK && fill_ff < FILL_W'(SQ_SIZE)
                         && !find_a.hit) begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  OP_COMPLETE: begin
                     op_pop    = 1'b1;
                     letter_in = CHAR_A;
                     state_in  = S_COMPLETE;
                  end
                  OP_PAIR: begin
                     if (rsp_stat.empty) begin
                        op_pop    = 1'b1;
                        pair_load = 1'b1;
                        state_in  = S_CALC;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_COMPLETE: begin
            if (letter_ff != CHAR_W && fill_ff < FILL_W'(SQ_SIZE) && !find_a.hit) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + 1'b1;
            end
            letter_in = letter_ff + 1'b1;
            if (letter_ff == CHAR_Z) begin
               state_in = S_IDLE;
            end
         end
         S_CALC: begin
            state_in = S_EMIT0;
         end
         S_EMIT0: begin
            rsp_push = 1'b1;
            state_in = S_EMIT1;
         end
         S_EMIT1: begin
            rsp_push               = 1'b1;
            rsp_push_data.out_char = in_b_ff ? rd_b_ff : CHAR_BLANK;
            rsp_push_data.last     = 1'b1;
            state_in               = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sq_ff[fill_ff[POS_W-1:0]]  <= srch_a_char;
         sq_mem[fill_ff[POS_W-1:0]] <= srch_a_char;
      end
      if (state_ff == S_CALC) begin
         rd_a_ff <= sq_mem[oa];
         rd_b_ff <= sq_mem[ob];
         in_a_ff <= (oa < fill_ff);
         in_b_ff <= (ob < fill_ff);
      end
      if (pair_load) begin
         pos_a_ff <= find_a.pos;
         pos_b_ff <= find_b.pos;
         dec_ff   <= op_head.decrypt;
      end
      letter_ff <= letter_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   `PDC_ASSERT(a_push_room, rsp_push |-> !rsp_stat.full)
   `PDC_ASSERT(a_pop_idle, op_pop |-> (state_ff == S_IDLE) && !opq_stat.empty)
   `PDC_ASSERT(a_emit_pair, (state_ff == S_EMIT0) |=> (state_ff == S_EMIT1) && rsp_push)
   `PDC_ASSERT(a_fill_step, (fill_ff != $past(fill_ff)) |-> (fill_ff == '0) || (fill_ff == $past(fill_ff) + 1'b1))
   `PDC_ASSERT_RST(a_reset_idle, reset |=> (state_ff == S_IDLE) && (fill_ff == '0))

endmodule

// ===== design/pdc_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// Playfair cipher result queue
// Output queue that holds result beats until the receiver pops them.
// ----------------------------------------------------------------------------
module pdc_rsp_queue import pdc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  rsp_type   push_data,
   input  logic      pop,
   output rsp_type   head,
   output qstat_type stat
);

   rsp_type                entry_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_CNT_W-1:0]  count_ff, count_in;
   logic                   do_push, do_pop;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == RSPQ_CNT_W'(RSPQ_DEPTH));
   assign do_push    = push & ~stat.full;
   assign do_pop     = pop & ~stat.empty;
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == RSPQ_PTR_W'(RSPQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == RSPQ_PTR_W'(RSPQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/playfair_digraph_cipher_top.sv =====
// ----------------------------------------------------------------------------
// Playfair digraph cipher
// Streaming Playfair cipher over a 5x5 key square, built from a front end,
// an operation queue, a back end with the key square and a result queue.
// ----------------------------------------------------------------------------
// Command beats enter on the req_ queue port: a beat is taken when req_push
// is high and req_full is low. Result beats leave on the rsp_ queue port:
// the oldest one is shown while rsp_empty is low and is taken on rsp_pop.
// The csr_ port writes the decrypt mode bit; it is always ready and should
// be written only while the block is idle.
// Clear and key beats are each handled by the back end in its idle state.
// Completing the square first moves the back end into its completion state
// and then walks the alphabet from a to z, one letter a cycle. A digraph
// passes through a search, an address and read step and two emits. A new
// pair starts only once the two-entry result queue has drained, so the back
// end does not take the next digraph before the last one's results are gone.
// Reset clears the fill count, the pending letter, the mode and both
// queues. When the receiver stalls, the result queue fills, the back end
// waits, the operation queue fills and req_full rises.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_top import pdc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   logic      op_push;
   op_type    op_data;
   op_type    op_head;
   logic      op_pop;
   qstat_type opq_stat;
   logic      rsp_push;
   rsp_type   rsp_push_data;
   qstat_type rsp_stat;

   pdc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .op_push   (op_push),
      .op_data   (op_data),
      .opq_stat  (opq_stat)
   );

   pdc_op_queue u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_data),
      .pop       (op_pop),
      .head      (op_head),
      .stat      (opq_stat)
   );

   pdc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .op_head       (op_head),
      .opq_stat      (opq_stat),
      .op_pop        (op_pop),
      .rsp_push      (rsp_push),
      .rsp_push_data (rsp_push_data),
      .rsp_stat      (rsp_stat)
   );

   pdc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_push_data),
      .pop       (rsp_pop),
      .head      (rsp_data),
      .stat      (rsp_stat)
   );

   assign rsp_empty = rsp_stat.empty;

endmodule
